// File: rtl/ibrs_pkg.sv
package ibrs_pkg;

   // Defaults for the top-level parameters.
   localparam int DEF_ADDR_BITS = 32;
   localparam int DEF_MAX_BANKS = 64;
   localparam int QUEUE_DEPTH   = 2;

   // Fixed field widths.
   localparam int BYTE_W  = 8;
   localparam int ALIGN_W = 8;

   // Bits carried by the descriptor besides the running offset:
   // remaining byte count, first-chunk alignment and the write flag.
   localparam int DESC_CTRL_W = BYTE_W + ALIGN_W + 1;

   localparam logic [BYTE_W-1:0] MAX_BYTES = 8'd128;
   localparam logic [3:0]        IB_MIN    = 4'd2;
   localparam logic [3:0]        IB_MAX    = 4'd8;
   localparam logic [2:0]        BB_MAX    = 3'd6;

   localparam logic [3:0]  RST_INTERLEAVE_BITS = 4'd2;
   localparam logic [2:0]  RST_BANK_BITS       = 3'd2;
   localparam logic [6:0]  RST_BANK_COUNT      = 7'd4;
   localparam logic [31:0] RST_BASE_OFFSET     = 32'd0;

   typedef enum logic [1:0] {
      CSR_INTERLEAVE_BITS = 2'd0,
      CSR_BANK_BITS       = 2'd1,
      CSR_BANK_COUNT      = 2'd2,
      CSR_BASE_OFFSET     = 2'd3
   } csr_index_type;

   // Configuration after range clamping, shared by the front and back ends.
   typedef struct packed {
      logic [3:0] interleave_bits;
      logic [2:0] bank_bits;
      logic [6:0] bank_count;
   } cfg_type;

endpackage

// File: rtl/ibrs_front.sv
module ibrs_front import ibrs_pkg::*; #(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cfg_type                              cfg,
   input  logic [31:0]                          base_offset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [31:0]                          req_address,
   input  logic [BYTE_W-1:0]                    req_byte_count,
   input  logic                                 req_write,
   output logic                                 desc_valid,
   input  logic                                 desc_ready,
   output logic [ADDR_BITS+DESC_CTRL_W-1:0]     desc_data
);

   localparam int DESC_W = ADDR_BITS + DESC_CTRL_W;

   logic              desc_valid_ff, desc_valid_in;
   logic [DESC_W-1:0] desc_data_ff, desc_data_in;
   logic              accept;
   logic [BYTE_W-1:0] count_sat;
   logic [8:0]        word_bytes;
   logic [8:0]        low_bits;
   logic [8:0]        align_full;
   logic [ADDR_BITS-1:0] offset;

   assign req_stall  = desc_valid_ff && !desc_ready;
   assign accept     = req_valid && !req_stall;
   assign desc_valid = desc_valid_ff;
   assign desc_data  = desc_data_ff;

   always_comb begin
      count_sat  = (req_byte_count > MAX_BYTES) ? MAX_BYTES : req_byte_count;
      word_bytes = 9'd1 << cfg.interleave_bits;
      // Alignment is judged on the address before the base is removed.
      low_bits   = {1'b0, req_address[7:0]} & (word_bytes - 9'd1);
      align_full = (low_bits == 9'd0) ? 9'd0 : (word_bytes - low_bits);
      offset     = ADDR_BITS'(req_address) - ADDR_BITS'(base_offset);

      desc_valid_in = desc_valid_ff && !desc_ready;
      desc_data_in  = desc_data_ff;
      if (accept) begin
         // An empty access produces no chunks and is dropped here.
         desc_valid_in = (count_sat != '0);
         desc_data_in  = {offset, count_sat, align_full[ALIGN_W-1:0], req_write};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         desc_valid_ff <= 1'b0;
      end else begin
         desc_valid_ff <= desc_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_data_ff <= desc_data_in;
   end

endmodule

// File: rtl/ibrs_queue.sv
module ibrs_queue import ibrs_pkg::*; #(
   parameter int WIDTH = DEF_ADDR_BITS + DESC_CTRL_W,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ibrs_back.sv
module ibrs_back import ibrs_pkg::*; #(
   parameter int ADDR_BITS = DEF_ADDR_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cfg_type                          cfg,
   input  logic                             desc_valid,
   output logic                             desc_ready,
   input  logic [ADDR_BITS+DESC_CTRL_W-1:0] desc_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [5:0]                       rsp_bank,
   output logic [31:0]                      rsp_bank_offset,
   output logic [BYTE_W-1:0]                rsp_chunk_size,
   output logic [6:0]                       rsp_data_position,
   output logic                             rsp_write_flag,
   output logic                             rsp_status,
   output logic                             rsp_last
);

   // Chunk walker state.
   logic                 active_ff, active_in;
   logic [ADDR_BITS-1:0] offset_ff, offset_in;
   logic [BYTE_W-1:0]    remain_ff, remain_in;
   logic [ALIGN_W-1:0]   align_ff, align_in;
   logic [BYTE_W-1:0]    pos_ff, pos_in;
   logic                 wr_ff, wr_in;

   // Output register.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [5:0]           bank_ff;
   logic [31:0]          boff_ff;
   logic [BYTE_W-1:0]    size_ff;
   logic [6:0]           dpos_ff;
   logic                 wflag_ff, status_ff, last_ff;

   logic                 fire, final_chunk, bad;
   logic [8:0]           word_bytes, size_first;
   logic [BYTE_W-1:0]    size;
   logic [BYTE_W-1:0]    remain_next;
   logic [ADDR_BITS-1:0] shifted, low_mask, high_mask, boff;
   logic [5:0]           bank_mask, bank;
   logic [4:0]           field_top;

   logic [ADDR_BITS-1:0] d_offset;
   logic [BYTE_W-1:0]    d_remain;
   logic [ALIGN_W-1:0]   d_align;
   logic                 d_wr;

   assign {d_offset, d_remain, d_align, d_wr} = desc_data;

   always_comb begin
      word_bytes = 9'd1 << cfg.interleave_bits;
      size_first = (align_ff != '0) ? {1'b0, align_ff} : word_bytes;
      size       = (size_first > {1'b0, remain_ff}) ? remain_ff : size_first[BYTE_W-1:0];

      shifted    = offset_ff >> cfg.interleave_bits;
      bank_mask  = 6'((7'd1 << cfg.bank_bits) - 7'd1);
      bank       = shifted[5:0] & bank_mask;

      // The in-bank offset squeezes the bank field out of the address.
      field_top  = 5'(cfg.interleave_bits) + 5'(cfg.bank_bits);
      low_mask   = (ADDR_BITS'(1) << cfg.interleave_bits) - ADDR_BITS'(1);
      high_mask  = ~((ADDR_BITS'(1) << field_top) - ADDR_BITS'(1));
      boff       = ((offset_ff & high_mask) >> cfg.bank_bits) | (offset_ff & low_mask);

      bad         = ({1'b0, bank} >= cfg.bank_count);
      remain_next = remain_ff - size;
      final_chunk = bad || (remain_next == '0);

      fire       = active_ff && (!rsp_valid_ff || !rsp_stall);
      desc_ready = !active_ff || (fire && final_chunk);

      active_in = active_ff;
      offset_in = offset_ff;
      remain_in = remain_ff;
      align_in  = align_ff;
      pos_in    = pos_ff;
      wr_in     = wr_ff;
      if (fire) begin
         active_in = !final_chunk;
         offset_in = offset_ff + ADDR_BITS'(size);
         remain_in = remain_next;
         align_in  = '0;
         pos_in    = pos_ff + size;
      end
      if (desc_valid && desc_ready) begin
         active_in = 1'b1;
         offset_in = d_offset;
         remain_in = d_remain;
         align_in  = d_align;
         pos_in    = '0;
         wr_in     = d_wr;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff <= offset_in;
      remain_ff <= remain_in;
      align_ff  <= align_in;
      pos_ff    <= pos_in;
      wr_ff     <= wr_in;
      if (fire) begin
         bank_ff   <= bank;
         boff_ff   <= 32'(boff);
         size_ff   <= size;
         dpos_ff   <= pos_ff[6:0];
         wflag_ff  <= wr_ff;
         status_ff <= bad;
         last_ff   <= final_chunk;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_bank          = bank_ff;
   assign rsp_bank_offset   = boff_ff;
   assign rsp_chunk_size    = size_ff;
   assign rsp_data_position = dpos_ff;
   assign rsp_write_flag    = wflag_ff;
   assign rsp_status        = status_ff;
   assign rsp_last          = last_ff;

`ifndef NO_ASSERTIONS
   a_bad_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff |-> last_ff)
      else $error("invalid bank chunk not marked last");

   a_chunk_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> size_ff != '0)
      else $error("empty chunk emitted");

   a_active_has_bytes: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> remain_ff != '0)
      else $error("walker active with no bytes left");

   a_final_stops: assert property (@(posedge clock) disable iff (reset)
      fire && final_chunk && !desc_valid |=> !active_ff)
      else $error("walker kept running after final chunk");
`endif

endmodule

// File: rtl/interleaved_bank_request_splitter.sv
// The first chunk of an access reaches the rsp ports through the front register, the
// queue, the chunk walker and the output register, in that order.
// Throughput: the back end emits one chunk per cycle unless the result channel stalls;
// a two-entry queue lets the front take further words while an access is being split.
// Reset (synchronous, active high) empties the pipeline and restores the configuration
// registers to their defaults.
module interleaved_bank_request_splitter import ibrs_pkg::*; #(
   parameter int ADDR_BITS = DEF_ADDR_BITS,
   parameter int MAX_BANKS = DEF_MAX_BANKS
) (
   input  logic              clock,
   input  logic              reset,
   // Configuration write channel.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_data,
   // Request channel.
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [31:0]       req_address,
   input  logic [BYTE_W-1:0] req_byte_count,
   input  logic              req_write,
   // Result channel, one word per chunk.
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [5:0]        rsp_bank,
   output logic [31:0]       rsp_bank_offset,
   output logic [BYTE_W-1:0] rsp_chunk_size,
   output logic [6:0]        rsp_data_position,
   output logic              rsp_write_flag,
   output logic              rsp_status,
   output logic              rsp_last
);

   localparam int DESC_W = ADDR_BITS + DESC_CTRL_W;

   // Raw configuration registers, kept as written and clamped on use.
   logic [3:0]  interleave_bits_ff;
   logic [2:0]  bank_bits_ff;
   logic [6:0]  bank_count_ff;
   logic [31:0] base_offset_ff;
   cfg_type     cfg;

   logic              front_valid, front_ready;
   logic [DESC_W-1:0] front_data;
   logic              back_valid, back_ready;
   logic [DESC_W-1:0] back_data;

   // The register file can always take a write.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interleave_bits_ff <= RST_INTERLEAVE_BITS;
         bank_bits_ff       <= RST_BANK_BITS;
         bank_count_ff      <= RST_BANK_COUNT;
         base_offset_ff     <= RST_BASE_OFFSET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INTERLEAVE_BITS: interleave_bits_ff <= csr_data[3:0];
            CSR_BANK_BITS:       bank_bits_ff       <= csr_data[2:0];
            CSR_BANK_COUNT:      bank_count_ff      <= csr_data[6:0];
            CSR_BASE_OFFSET:     base_offset_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Out-of-range settings are pulled back into their legal range. A bank count of
   // zero is left alone, which makes every bank invalid.
   always_comb begin
      cfg.interleave_bits = (interleave_bits_ff < IB_MIN) ? IB_MIN :
                            (interleave_bits_ff > IB_MAX) ? IB_MAX : interleave_bits_ff;
      cfg.bank_bits       = (bank_bits_ff > BB_MAX) ? BB_MAX : bank_bits_ff;
      cfg.bank_count      = (bank_count_ff > 7'(MAX_BANKS)) ? 7'(MAX_BANKS) : bank_count_ff;
   end

   // The front end saturates the byte count, works out the first chunk's alignment
   // and removes the base, then hands a descriptor word to the queue.
   ibrs_front #(
      .ADDR_BITS (ADDR_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .base_offset    (base_offset_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_address    (req_address),
      .req_byte_count (req_byte_count),
      .req_write      (req_write),
      .desc_valid     (front_valid),
      .desc_ready     (front_ready),
      .desc_data      (front_data)
   );

   ibrs_queue #(
      .WIDTH (DESC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_data)
   );

   // The back end walks one descriptor chunk by chunk, decoding bank and in-bank
   // offset for each, and stops early at the first invalid bank.
   ibrs_back #(
      .ADDR_BITS (ADDR_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .desc_valid        (back_valid),
      .desc_ready        (back_ready),
      .desc_data         (back_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bank          (rsp_bank),
      .rsp_bank_offset   (rsp_bank_offset),
      .rsp_chunk_size    (rsp_chunk_size),
      .rsp_data_position (rsp_data_position),
      .rsp_write_flag    (rsp_write_flag),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

endmodule
